// ===== hw/rtl/adjacency_matrix_graph_store_core_assert.svh =====
// assertion helpers used by the graph store datapath rtl
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define AMGS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("graph store assertion failed");

// next-cycle implication, sampled on clk, off while reset is asserted
`define AMGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("graph store assertion failed");

`endif

// ===== hw/rtl/amgs_pkg.sv =====
// ----------------------------------------------------------------------------
// amgs_pkg
// shared constants, codes and controller/datapath interface types of the
// adjacency matrix graph store
// ----------------------------------------------------------------------------
`default_nettype none

package amgs_pkg;

    // sizes
    localparam int MAX_V     = 64;
    localparam int IDX_W     = $clog2(MAX_V);
    localparam int CNT_W     = $clog2(MAX_V + 1);
    localparam int KEY_W     = 32;
    localparam int WGT_W     = 32;
    localparam int CELL_AW   = 2 * IDX_W;
    localparam int CELLS     = MAX_V * MAX_V;
    localparam int CMD_W     = 4;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 1;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_V  = 4'd0,
        CMD_ADD_E  = 4'd1,
        CMD_DEL_V  = 4'd2,
        CMD_DEL_E  = 4'd3,
        CMD_CHK_V  = 4'd4,
        CMD_CHK_E  = 4'd5,
        CMD_DEG    = 4'd6,
        CMD_INDEG  = 4'd7,
        CMD_OUTDEG = 4'd8,
        CMD_WEIGHT = 4'd9
    } cmd_code_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_EXISTS     = 3'd1,
        ST_FROM_MISS  = 3'd2,
        ST_TO_MISS    = 3'd3,
        ST_NO_EDGE    = 3'd4,
        ST_UNDIRECTED = 3'd5,
        ST_UNWEIGHTED = 3'd6,
        ST_FULL       = 3'd7
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTED = 1'b0,
        CFG_WEIGHTED = 1'b1
    } cfg_reg_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SRCH,
        OP_CRD,
        OP_CWR_FT_ABS,
        OP_CWR_TF_ABS,
        OP_CWR_FT_VAL,
        OP_CWR_TF_VAL,
        OP_AV_KEY,
        OP_AV_ROW,
        OP_AV_COL,
        OP_AV_END,
        OP_DV_INIT,
        OP_DV_KRD,
        OP_DV_KWR,
        OP_DV_CRD,
        OP_DV_CWR,
        OP_DV_END,
        OP_DEG_INIT,
        OP_DEG,
        OP_RES,
        OP_PUSH
    } dp_op_t;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_SRCH,
        S_DISP,
        S_DE_CHK,
        S_DE_MIR,
        S_AE_MIR,
        S_CHK_E,
        S_WT,
        S_AV_ROW,
        S_AV_COL,
        S_AV_END,
        S_DV_KCHK,
        S_DV_KRD,
        S_DV_KWR,
        S_DV_CRD,
        S_DV_CWR,
        S_DV_END,
        S_DEG,
        S_DEG_RES,
        S_FIN,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t  op;
        status_t res_status;
        logic    res_found;
        logic    res_deg;
        logic    res_wt;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      fi_ok;
        logic      ti_ok;
        logic      directed;
        logic      weighted;
        logic      cnt_full;
        logic      cell_absent;
        logic      idx_at_cnt;
        logic      key_more;
        logic      cells_none;
        logic      cell_last;
        logic      out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adjacency_matrix_graph_store_core.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_core
// keyed vertex store with a dense adjacency matrix: vertex and edge
// insert, delete, lookup, degree and weight commands, one result per beat
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid / in_ready       command, from_key, to_key, edge_weight
//  out       out_valid / out_ready     status, found, degree, weight_out
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one beat at a time; every command first scans the key table, one entry a
//  cycle, over all n stored vertices (single key read port)
//  degree commands add another scan of one row or column
//  add vertex adds 2(n + 1) cell writes; delete vertex shifts each later key
//  down, then compacts the (n - 1)^2 kept cells with a read and a write each (one cell read port)
//  reset is asynchronous; memories start undefined and need no clearing pass
//  a stalled result waits in the output register; the next beat is taken
//  while it waits
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_graph_store_core
    import amgs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [CMD_W-1:0]        command,
    input  wire logic [KEY_W-1:0]        from_key,
    input  wire logic [KEY_W-1:0]        to_key,
    input  wire logic signed [WGT_W-1:0] edge_weight,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STAT_W-1:0]            status,
    output logic                         found,
    output logic [CNT_W-1:0]             degree,
    output logic signed [WGT_W-1:0]      weight_out,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic                    cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // mode registers always take a write
    assign cfg_ready = 1'b1;

    // sequencer
    amgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    // storage and result path
    amgs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .stat        (dp_stat),
        .command     (command),
        .from_key    (from_key),
        .to_key      (to_key),
        .edge_weight (edge_weight),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .degree      (degree),
        .weight_out  (weight_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/amgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// amgs_ctrl
// command sequencer: key search, command dispatch, edit loops and result
// hand-off, driving the datapath one micro-operation per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module amgs_ctrl
    import amgs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       dp_cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and micro-operation
    always_comb
    begin
        state_next        = state_reg;
        in_ready          = 1'b0;
        dp_cmd.op         = OP_NONE;
        dp_cmd.res_status = ST_OK;
        dp_cmd.res_found  = 1'b0;
        dp_cmd.res_deg    = 1'b0;
        dp_cmd.res_wt     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.op  = OP_LOAD;
                    state_next = S_SRCH;
                end
            end

            S_SRCH:
            begin
                dp_cmd.op = OP_SRCH;
                if (stat.idx_at_cnt)
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                state_next = S_OUT;
                dp_cmd.op  = OP_RES;
                case (stat.cmd)
                    CMD_ADD_V:
                    begin
                        if (stat.fi_ok)
                        begin
                            dp_cmd.res_status = ST_EXISTS;
                        end
                        else if (stat.cnt_full)
                        begin
                            dp_cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            dp_cmd.op  = OP_AV_KEY;
                            state_next = S_AV_ROW;
                        end
                    end
                    CMD_ADD_E:
                    begin
                        if (!stat.fi_ok)
                        begin
                            dp_cmd.res_status = ST_FROM_MISS;
                        end
                        else if (!stat.ti_ok)
                        begin
                            dp_cmd.res_status = ST_TO_MISS;
                        end
                        else
                        begin
                            dp_cmd.op  = OP_CWR_FT_VAL;
                            state_next = stat.directed ? S_FIN : S_AE_MIR;
                        end
                    end
                    CMD_DEL_V:
                    begin
                        if (!stat.fi_ok)
                        begin
                            dp_cmd.res_status = ST_FROM_MISS;
                        end
                        else
                        begin
                            dp_cmd.op  = OP_DV_INIT;
                            state_next = S_DV_KCHK;
                        end
                    end
                    CMD_DEL_E:
                    begin
                        if (!stat.fi_ok)
                        begin
                            dp_cmd.res_status = ST_FROM_MISS;
                        end
                        else if (!stat.ti_ok)
                        begin
                            dp_cmd.res_status = ST_TO_MISS;
                        end
                        else
                        begin
                            dp_cmd.op  = OP_CRD;
                            state_next = S_DE_CHK;
                        end
                    end
                    CMD_CHK_V:
                    begin
                        dp_cmd.res_found = stat.fi_ok;
                    end
                    CMD_CHK_E:
                    begin
                        if (stat.fi_ok && stat.ti_ok)
                        begin
                            dp_cmd.op  = OP_CRD;
                            state_next = S_CHK_E;
                        end
                    end
                    CMD_DEG, CMD_INDEG, CMD_OUTDEG:
                    begin
                        if (stat.cmd != CMD_DEG && !stat.directed)
                        begin
                            dp_cmd.res_status = ST_UNDIRECTED;
                        end
                        else if (!stat.fi_ok)
                        begin
                            dp_cmd.res_status = ST_FROM_MISS;
                        end
                        else
                        begin
                            dp_cmd.op  = OP_DEG_INIT;
                            state_next = S_DEG;
                        end
                    end
                    CMD_WEIGHT:
                    begin
                        if (!stat.weighted)
                        begin
                            dp_cmd.res_status = ST_UNWEIGHTED;
                        end
                        else if (!stat.fi_ok)
                        begin
                            dp_cmd.res_status = ST_FROM_MISS;
                        end
                        else if (!stat.ti_ok)
                        begin
                            dp_cmd.res_status = ST_TO_MISS;
                        end
                        else
                        begin
                            dp_cmd.op  = OP_CRD;
                            state_next = S_WT;
                        end
                    end
                    default:
                    begin
                        dp_cmd.res_status = ST_OK;
                    end
                endcase
            end

            // delete edge: check presence, clear cell and, when undirected, its mirror
            S_DE_CHK:
            begin
                if (stat.cell_absent)
                begin
                    dp_cmd.op         = OP_RES;
                    dp_cmd.res_status = ST_NO_EDGE;
                    state_next        = S_OUT;
                end
                else
                begin
                    dp_cmd.op  = OP_CWR_FT_ABS;
                    state_next = stat.directed ? S_FIN : S_DE_MIR;
                end
            end

            S_DE_MIR:
            begin
                dp_cmd.op  = OP_CWR_TF_ABS;
                state_next = S_FIN;
            end

            S_AE_MIR:
            begin
                dp_cmd.op  = OP_CWR_TF_VAL;
                state_next = S_FIN;
            end

            S_CHK_E:
            begin
                dp_cmd.op        = OP_RES;
                dp_cmd.res_found = !stat.cell_absent;
                state_next       = S_OUT;
            end

            S_WT:
            begin
                dp_cmd.op     = OP_RES;
                dp_cmd.res_wt = 1'b1;
                state_next    = S_OUT;
            end

            // add vertex: clear new row and column, two writes per index
            S_AV_ROW:
            begin
                dp_cmd.op  = OP_AV_ROW;
                state_next = S_AV_COL;
            end

            S_AV_COL:
            begin
                dp_cmd.op  = OP_AV_COL;
                state_next = stat.idx_at_cnt ? S_AV_END : S_AV_ROW;
            end

            S_AV_END:
            begin
                dp_cmd.op  = OP_AV_END;
                state_next = S_FIN;
            end

            // delete vertex: shift keys, then compact the matrix
            S_DV_KCHK:
            begin
                if (stat.key_more)
                begin
                    state_next = S_DV_KRD;
                end
                else if (stat.cells_none)
                begin
                    state_next = S_DV_END;
                end
                else
                begin
                    state_next = S_DV_CRD;
                end
            end

            S_DV_KRD:
            begin
                dp_cmd.op  = OP_DV_KRD;
                state_next = S_DV_KWR;
            end

            S_DV_KWR:
            begin
                dp_cmd.op  = OP_DV_KWR;
                state_next = S_DV_KCHK;
            end

            S_DV_CRD:
            begin
                dp_cmd.op  = OP_DV_CRD;
                state_next = S_DV_CWR;
            end

            S_DV_CWR:
            begin
                dp_cmd.op  = OP_DV_CWR;
                state_next = stat.cell_last ? S_DV_END : S_DV_CRD;
            end

            S_DV_END:
            begin
                dp_cmd.op  = OP_DV_END;
                state_next = S_FIN;
            end

            // degree scan
            S_DEG:
            begin
                dp_cmd.op = OP_DEG;
                if (stat.idx_at_cnt)
                begin
                    state_next = S_DEG_RES;
                end
            end

            S_DEG_RES:
            begin
                dp_cmd.op      = OP_RES;
                dp_cmd.res_deg = 1'b1;
                state_next     = S_OUT;
            end

            S_FIN:
            begin
                dp_cmd.op  = OP_RES;
                state_next = S_OUT;
            end

            // hand the result to the output register once it is free
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    dp_cmd.op  = OP_PUSH;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/amgs_dp.sv =====
// ----------------------------------------------------------------------------
// amgs_dp
// datapath: key table and cell matrix memories, index counters, mode
// registers and the result output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "adjacency_matrix_graph_store_core_assert.svh"

module amgs_dp
    import amgs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               dp_cmd,
    output dp_stat_t                   stat,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [KEY_W-1:0]      from_key,
    input  wire logic [KEY_W-1:0]      to_key,
    input  wire logic signed [WGT_W-1:0] edge_weight,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic                  cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [STAT_W-1:0]          status,
    output logic                       found,
    output logic [CNT_W-1:0]           degree,
    output logic signed [WGT_W-1:0]    weight_out
);

    // memories
    logic [KEY_W-1:0] key_mem  [MAX_V];
    logic [WGT_W-1:0] cell_mem [CELLS];

    logic [KEY_W-1:0] key_q_reg;
    logic [WGT_W-1:0] cell_q_reg;

    // mode registers
    logic directed_reg;
    logic weighted_reg;

    // item registers
    cmd_code_t        cmd_reg;
    logic [KEY_W-1:0] fk_reg;
    logic [KEY_W-1:0] tk_reg;
    logic [WGT_W-1:0] w_reg;

    // control state
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [CNT_W-1:0] idx_reg,  idx_next;
    logic [IDX_W-1:0] row_reg,  row_next;
    logic [IDX_W-1:0] col_reg,  col_next;
    logic [IDX_W-1:0] fi_reg,   fi_next;
    logic [IDX_W-1:0] ti_reg,   ti_next;
    logic             fi_ok_reg, fi_ok_next;
    logic             ti_ok_reg, ti_ok_next;
    logic [CNT_W-1:0] deg_reg,  deg_next;
    logic             out_valid_reg, out_valid_next;

    // pending result and output payload
    status_t          pend_status_reg;
    logic             pend_found_reg;
    logic [CNT_W-1:0] pend_deg_reg;
    logic [WGT_W-1:0] pend_wt_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic             out_found_reg;
    logic [CNT_W-1:0] out_deg_reg;
    logic [WGT_W-1:0] out_wt_reg;

    // memory port controls
    logic               kw_en, kr_en, cw_en, cr_en;
    logic [IDX_W-1:0]   kw_addr, kr_addr;
    logic [KEY_W-1:0]   kw_data;
    logic [CELL_AW-1:0] cw_addr, cr_addr;
    logic [WGT_W-1:0]   cw_data;

    // derived values
    logic [WGT_W-1:0] absent;
    logic [WGT_W-1:0] edge_val;
    logic [IDX_W-1:0] idx_lo;
    logic [IDX_W-1:0] idx_prev;
    logic [IDX_W-1:0] cnt_lo;
    logic [IDX_W-1:0] last_lo;
    logic [CNT_W-1:0] idx_inc;
    logic             idx_live;
    logic [IDX_W-1:0] src_row;
    logic [IDX_W-1:0] src_col;

    assign absent   = weighted_reg ? {WGT_W{1'b1}} : {WGT_W{1'b0}};
    assign edge_val = weighted_reg ? w_reg : WGT_W'(1);
    assign idx_lo   = idx_reg[IDX_W-1:0];
    assign idx_prev = IDX_W'(idx_reg - CNT_W'(1));
    assign cnt_lo   = cnt_reg[IDX_W-1:0];
    assign last_lo  = IDX_W'(cnt_reg - CNT_W'(2));
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_live = (idx_reg < cnt_reg);
    assign src_row  = (row_reg >= fi_reg) ? IDX_W'(row_reg + IDX_W'(1)) : row_reg;
    assign src_col  = (col_reg >= fi_reg) ? IDX_W'(col_reg + IDX_W'(1)) : col_reg;

    // status to the controller
    assign stat.cmd         = cmd_reg;
    assign stat.fi_ok       = fi_ok_reg;
    assign stat.ti_ok       = ti_ok_reg;
    assign stat.directed    = directed_reg;
    assign stat.weighted    = weighted_reg;
    assign stat.cnt_full    = (cnt_reg == CNT_W'(MAX_V));
    assign stat.cell_absent = (cell_q_reg == absent);
    assign stat.idx_at_cnt  = (idx_reg == cnt_reg);
    assign stat.key_more    = (idx_inc < cnt_reg);
    assign stat.cells_none  = (cnt_reg <= CNT_W'(1));
    assign stat.cell_last   = (row_reg == last_lo) && (col_reg == last_lo);
    assign stat.out_free    = !out_valid_reg || out_ready;

    // micro-operation decode
    always_comb
    begin
        kw_en      = 1'b0;
        kw_addr    = idx_lo;
        kw_data    = key_q_reg;
        kr_en      = 1'b0;
        kr_addr    = idx_lo;
        cw_en      = 1'b0;
        cw_addr    = {fi_reg, ti_reg};
        cw_data    = absent;
        cr_en      = 1'b0;
        cr_addr    = {fi_reg, ti_reg};
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        fi_next    = fi_reg;
        ti_next    = ti_reg;
        fi_ok_next = fi_ok_reg;
        ti_ok_next = ti_ok_reg;
        deg_next   = deg_reg;

        unique case (dp_cmd.op)
            OP_LOAD:
            begin
                idx_next   = '0;
                fi_ok_next = 1'b0;
                ti_ok_next = 1'b0;
            end
            // read entry idx, compare the entry read last cycle
            OP_SRCH:
            begin
                kr_en = idx_live;
                if (idx_reg != '0 && !fi_ok_reg && key_q_reg == fk_reg)
                begin
                    fi_next    = idx_prev;
                    fi_ok_next = 1'b1;
                end
                if (idx_reg != '0 && !ti_ok_reg && key_q_reg == tk_reg)
                begin
                    ti_next    = idx_prev;
                    ti_ok_next = 1'b1;
                end
                if (idx_live)
                begin
                    idx_next = idx_inc;
                end
            end
            OP_CRD:
            begin
                cr_en = 1'b1;
            end
            OP_CWR_FT_ABS:
            begin
                cw_en = 1'b1;
            end
            OP_CWR_TF_ABS:
            begin
                cw_en   = 1'b1;
                cw_addr = {ti_reg, fi_reg};
            end
            OP_CWR_FT_VAL:
            begin
                cw_en   = 1'b1;
                cw_data = edge_val;
            end
            OP_CWR_TF_VAL:
            begin
                cw_en   = 1'b1;
                cw_addr = {ti_reg, fi_reg};
                cw_data = edge_val;
            end
            OP_AV_KEY:
            begin
                kw_en    = 1'b1;
                kw_addr  = cnt_lo;
                kw_data  = fk_reg;
                idx_next = '0;
            end
            OP_AV_ROW:
            begin
                cw_en   = 1'b1;
                cw_addr = {cnt_lo, idx_lo};
            end
            OP_AV_COL:
            begin
                cw_en    = 1'b1;
                cw_addr  = {idx_lo, cnt_lo};
                idx_next = idx_inc;
            end
            OP_AV_END:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_DV_INIT:
            begin
                idx_next = CNT_W'(fi_reg);
                row_next = '0;
                col_next = '0;
            end
            OP_DV_KRD:
            begin
                kr_en   = 1'b1;
                kr_addr = idx_inc[IDX_W-1:0];
            end
            OP_DV_KWR:
            begin
                kw_en    = 1'b1;
                idx_next = idx_inc;
            end
            OP_DV_CRD:
            begin
                cr_en   = 1'b1;
                cr_addr = {src_row, src_col};
            end
            // destinations never run ahead of their sources, so in place is safe
            OP_DV_CWR:
            begin
                cw_en   = 1'b1;
                cw_addr = {row_reg, col_reg};
                cw_data = cell_q_reg;
                if (col_reg == last_lo)
                begin
                    col_next = '0;
                    row_next = row_reg + IDX_W'(1);
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            OP_DV_END:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_DEG_INIT:
            begin
                idx_next = '0;
                deg_next = '0;
            end
            // in-degree walks the column, the others the row
            OP_DEG:
            begin
                cr_en   = idx_live;
                cr_addr = (cmd_reg == CMD_INDEG) ? {idx_lo, fi_reg} : {fi_reg, idx_lo};
                if (idx_reg != '0 && cell_q_reg != absent)
                begin
                    deg_next = deg_reg + CNT_W'(1);
                end
                if (idx_live)
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.op == OP_PUSH)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // key table
    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            key_mem[kw_addr] <= kw_data;
        end
        if (kr_en)
        begin
            key_q_reg <= key_mem[kr_addr];
        end
    end

    // cell matrix
    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cell_mem[cw_addr] <= cw_data;
        end
        if (cr_en)
        begin
            cell_q_reg <= cell_mem[cr_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg  <= 1'b0;
            weighted_reg  <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            fi_reg        <= '0;
            ti_reg        <= '0;
            fi_ok_reg     <= 1'b0;
            ti_ok_reg     <= 1'b0;
            deg_reg       <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_ADD_V;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_DIRECTED: directed_reg <= cfg_data;
                    CFG_WEIGHTED: weighted_reg <= cfg_data;
                    default:      directed_reg <= directed_reg;
                endcase
            end
            if (dp_cmd.op == OP_LOAD)
            begin
                cmd_reg <= cmd_code_t'(command);
            end
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            fi_reg        <= fi_next;
            ti_reg        <= ti_next;
            fi_ok_reg     <= fi_ok_next;
            ti_ok_reg     <= ti_ok_next;
            deg_reg       <= deg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == OP_LOAD)
        begin
            fk_reg <= from_key;
            tk_reg <= to_key;
            w_reg  <= edge_weight;
        end
        if (dp_cmd.op == OP_RES)
        begin
            pend_status_reg <= dp_cmd.res_status;
            pend_found_reg  <= dp_cmd.res_found;
            pend_deg_reg    <= dp_cmd.res_deg ? deg_reg : '0;
            pend_wt_reg     <= dp_cmd.res_wt ? cell_q_reg : '0;
        end
        if (dp_cmd.op == OP_PUSH)
        begin
            out_status_reg <= pend_status_reg;
            out_found_reg  <= pend_found_reg;
            out_deg_reg    <= pend_deg_reg;
            out_wt_reg     <= pend_wt_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found      = out_found_reg;
    assign degree     = out_deg_reg;
    assign weight_out = out_wt_reg;

    // checks
    `AMGS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_V))
    `AMGS_ASSERT_IMPL(a_push_free, dp_cmd.op == OP_PUSH, !out_valid_reg || out_ready)
    `AMGS_ASSERT_NEXT(a_push_valid, dp_cmd.op == OP_PUSH, out_valid_reg)
    `AMGS_ASSERT_NEXT(a_av_grow, dp_cmd.op == OP_AV_END, cnt_reg == CNT_W'($past(cnt_reg) + 1'b1))

endmodule

`default_nettype wire

// ===== dv/adjacency_matrix_graph_store_core_test.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_core_test
// drives vertex and edge commands into the graph store under every mode
// setting and compares each result beat with a cycle-free model of the
// key table and adjacency matrix kept inside a small scoreboard class
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_graph_store_core_test;
    import amgs_pkg::*;

    localparam int STALL_LIMIT = 60000;

    // expected contents of one result beat
    typedef struct {
        logic [STAT_W-1:0]       status;
        logic                    found;
        logic [CNT_W-1:0]        degree;
        logic signed [WGT_W-1:0] weight;
    } graph_answer_t;

    // graph model and queue of pending answers
    class graph_scoreboard;
        logic [KEY_W-1:0]        keys [MAX_V];
        logic signed [WGT_W-1:0] cells [MAX_V][MAX_V];
        int                      count;
        logic                    directed;
        logic                    weighted;
        graph_answer_t           answers [$];
        int                      errors;
        int                      checked;

        function new();
            count    = 0;
            directed = 1'b0;
            weighted = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("error: %s", what);
        endtask

        function int lookup(input logic [KEY_W-1:0] k);
            for (int i = 0; i < count; i++)
                if (keys[i] == k)
                    return i;
            return -1;
        endfunction

        function void drop_vertex(input int idx);
            for (int r = idx; r < count - 1; r++)
            begin
                keys[r] = keys[r + 1];
                for (int c = 0; c < MAX_V; c++)
                    cells[r][c] = cells[r + 1][c];
            end
            for (int r = 0; r < count - 1; r++)
                for (int c = idx; c < count - 1; c++)
                    cells[r][c] = cells[r][c + 1];
            count--;
        endfunction

        // apply one accepted command and queue its answer
        function void note_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] fk,
                                   input logic [KEY_W-1:0] tk,
                                   input logic signed [WGT_W-1:0] w);
            graph_answer_t           a;
            logic signed [WGT_W-1:0] absent;
            logic signed [WGT_W-1:0] v;
            int                      fi;
            int                      ti;
            int                      n;
            a.status = ST_OK;
            a.found  = 1'b0;
            a.degree = '0;
            a.weight = '0;
            absent   = weighted ? -1 : 0;
            fi       = lookup(fk);
            ti       = lookup(tk);
            case (cmd)
                CMD_ADD_V:
                    if (fi >= 0)
                        a.status = ST_EXISTS;
                    else if (count >= MAX_V)
                        a.status = ST_FULL;
                    else
                    begin
                        keys[count] = fk;
                        for (int i = 0; i <= count; i++)
                        begin
                            cells[count][i] = absent;
                            cells[i][count] = absent;
                        end
                        count++;
                    end
                CMD_ADD_E:
                    if (fi < 0)
                        a.status = ST_FROM_MISS;
                    else if (ti < 0)
                        a.status = ST_TO_MISS;
                    else
                    begin
                        v = weighted ? w : 1;
                        cells[fi][ti] = v;
                        if (!directed)
                            cells[ti][fi] = v;
                    end
                CMD_DEL_V:
                    if (fi < 0)
                        a.status = ST_FROM_MISS;
                    else
                        drop_vertex(fi);
                CMD_DEL_E:
                    if (fi < 0)
                        a.status = ST_FROM_MISS;
                    else if (ti < 0)
                        a.status = ST_TO_MISS;
                    else if (cells[fi][ti] == absent)
                        a.status = ST_NO_EDGE;
                    else
                    begin
                        cells[fi][ti] = absent;
                        if (!directed)
                            cells[ti][fi] = absent;
                    end
                CMD_CHK_V:
                    a.found = (fi >= 0);
                CMD_CHK_E:
                    a.found = (fi >= 0 && ti >= 0) ? (cells[fi][ti] != absent) : 1'b0;
                CMD_DEG, CMD_INDEG, CMD_OUTDEG:
                    if (cmd != CMD_DEG && !directed)
                        a.status = ST_UNDIRECTED;
                    else if (fi < 0)
                        a.status = ST_FROM_MISS;
                    else
                    begin
                        n = 0;
                        for (int i = 0; i < count; i++)
                            if (((cmd == CMD_INDEG) ? cells[i][fi] : cells[fi][i]) != absent)
                                n++;
                        a.degree = n[CNT_W-1:0];
                    end
                CMD_WEIGHT:
                    if (!weighted)
                        a.status = ST_UNWEIGHTED;
                    else if (fi < 0)
                        a.status = ST_FROM_MISS;
                    else if (ti < 0)
                        a.status = ST_TO_MISS;
                    else
                        a.weight = cells[fi][ti];
                default: ;
            endcase
            answers.insert(answers.size(), a);
        endfunction

        // compare one result beat with the oldest pending answer
        task check_result(input logic [STAT_W-1:0] st, input logic fnd,
                          input logic [CNT_W-1:0] deg, input logic signed [WGT_W-1:0] wt);
            graph_answer_t a;
            if (answers.size() == 0)
            begin
                report_mismatch("result beat with no command pending");
                return;
            end
            a = answers.pop_front();
            checked++;
            if (st !== a.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, a.status));
            if (fnd !== a.found)
                report_mismatch($sformatf("found %0d, expected %0d", fnd, a.found));
            if (deg !== a.degree)
                report_mismatch($sformatf("degree %0d, expected %0d", deg, a.degree));
            if (wt !== a.weight)
                report_mismatch($sformatf("weight_out %h, expected %h", wt, a.weight));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [CMD_W-1:0]        command;
    logic [KEY_W-1:0]        from_key;
    logic [KEY_W-1:0]        to_key;
    logic signed [WGT_W-1:0] edge_weight;
    logic                    out_valid;
    logic                    out_ready;
    logic [STAT_W-1:0]       status;
    logic                    found;
    logic [CNT_W-1:0]        degree;
    logic signed [WGT_W-1:0] weight_out;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic                    cfg_data;

    graph_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              sent;
    int              stall_cycles;
    logic [KEY_W-1:0] key_pool [12];

    adjacency_matrix_graph_store_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .from_key    (from_key),
        .to_key      (to_key),
        .edge_weight (edge_weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .degree      (degree),
        .weight_out  (weight_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // beat monitors
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_command(command, from_key, to_key, edge_weight);
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, found, degree, weight_out);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("adjacency_matrix_graph_store_core: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // one command beat, with a random gap before it
    task send_command(input cmd_code_t cmd, input logic [KEY_W-1:0] fk,
                      input logic [KEY_W-1:0] tk, input logic [WGT_W-1:0] w);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        from_key    <= fk;
        to_key      <= tk;
        edge_weight <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task send_raw(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] fk,
                  input logic [KEY_W-1:0] tk, input logic [WGT_W-1:0] w);
        send_command(cmd_code_t'(cmd), fk, tk, w);
    endtask

    task drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.answers.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task write_register(input cfg_reg_t idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DIRECTED)
            sb.directed = val;
        else
            sb.weighted = val;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, 11)];
        return $urandom;
    endfunction

    function automatic logic [WGT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'hFFFF_FFFF;
        if (r < 15)
            return 32'h7FFF_FFFF;
        if (r < 20)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    // vertex and edge inserts are the most common commands, so the graph stays populated
    task random_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            send_command(CMD_ADD_V, pick_key(), $urandom, $urandom);
        else if (r < 40)
            send_command(CMD_ADD_E, pick_key(), pick_key(), pick_weight());
        else if (r < 47)
            send_command(CMD_DEL_V, pick_key(), $urandom, $urandom);
        else if (r < 54)
            send_command(CMD_DEL_E, pick_key(), pick_key(), $urandom);
        else if (r < 61)
            send_command(CMD_CHK_V, pick_key(), $urandom, $urandom);
        else if (r < 69)
            send_command(CMD_CHK_E, pick_key(), pick_key(), $urandom);
        else if (r < 75)
            send_command(CMD_DEG, pick_key(), $urandom, $urandom);
        else if (r < 81)
            send_command(CMD_INDEG, pick_key(), $urandom, $urandom);
        else if (r < 87)
            send_command(CMD_OUTDEG, pick_key(), $urandom, $urandom);
        else if (r < 97)
            send_command(CMD_WEIGHT, pick_key(), pick_key(), $urandom);
        else
            send_raw(4'($urandom_range(10, 15)), $urandom, $urandom, $urandom);
    endtask

    // fill to capacity, query, then empty again
    task fill_graph();
        logic [KEY_W-1:0] fill_keys [MAX_V + 1];
        for (int i = 0; i <= MAX_V; i++)
        begin
            fill_keys[i] = $urandom;
            send_command(CMD_ADD_V, fill_keys[i], $urandom, $urandom);
        end
        for (int i = 0; i < 8; i++)
            send_command(CMD_ADD_E, fill_keys[$urandom_range(0, 20)],
                         fill_keys[$urandom_range(0, 20)], pick_weight());
        send_command(CMD_DEG, fill_keys[0], $urandom, $urandom);
        send_command(CMD_OUTDEG, fill_keys[1], $urandom, $urandom);
        send_command(CMD_INDEG, fill_keys[2], $urandom, $urandom);
        for (int i = 0; i <= MAX_V; i++)
            send_command(CMD_DEL_V, fill_keys[i], $urandom, $urandom);
    endtask

    // extremes and special cases, directed weighted mode
    task directed_checks();
        send_command(CMD_CHK_V, 32'h0, 32'h0, 32'h0);
        send_command(CMD_DEL_V, 32'h0, 32'h0, 32'h0);
        send_command(CMD_ADD_V, 32'h0, 32'h0, 32'h0);
        send_command(CMD_ADD_V, 32'h0, 32'h0, 32'h0);
        send_command(CMD_ADD_V, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_command(CMD_ADD_V, 32'h5, 32'h0, 32'h0);
        send_command(CMD_ADD_E, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_command(CMD_ADD_E, 32'h0, 32'h0, 32'h8000_0000);
        send_command(CMD_ADD_E, 32'h5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_ADD_E, 32'h7, 32'h0, 32'h1);
        send_command(CMD_ADD_E, 32'h0, 32'h7, 32'h1);
        send_command(CMD_CHK_E, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_CHK_E, 32'h5, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_WEIGHT, 32'h0, 32'h0, 32'h0);
        send_command(CMD_WEIGHT, 32'h5, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_WEIGHT, 32'h0, 32'h7, 32'h0);
        send_command(CMD_DEG, 32'h0, 32'h0, 32'h0);
        send_command(CMD_INDEG, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_command(CMD_OUTDEG, 32'h0, 32'h0, 32'h0);
        send_command(CMD_DEG, 32'h9, 32'h0, 32'h0);
        send_command(CMD_DEL_E, 32'h5, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_DEL_E, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_DEL_V, 32'h0, 32'h0, 32'h0);
        send_raw(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_raw(4'd10, 32'h5, 32'h5, 32'h0);
    endtask

    // phases: register settings change, idling profile follows the phase
    initial
    begin
        logic phase_dir [6];
        logic phase_wt [6];
        phase_dir = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_wt  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = '0;
        from_key      = '0;
        to_key        = '0;
        edge_weight   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_DIRECTED;
        cfg_data      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent          = 0;
        key_pool[0]   = 32'h0;
        key_pool[1]   = 32'hFFFF_FFFF;
        key_pool[2]   = 32'h8000_0000;
        key_pool[3]   = 32'h1;
        for (int i = 4; i < 12; i++)
            key_pool[i] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 15 : (p < 4) ? 68 : 0;
            recv_idle_pct = (p < 2) ? 68 : (p < 4) ? 15 : 0;
            write_register(CFG_DIRECTED, phase_dir[p]);
            write_register(CFG_WEIGHTED, phase_wt[p]);
            if (p == 0)
                directed_checks();
            if (p == 3)
                fill_graph();
            for (int i = 0; i < 190; i++)
                random_command();
            drain_results();
        end

        if (sb.answers.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.answers.size()));
        $display("sent %0d commands, checked %0d results over 6 mode settings",
                 sent, sb.checked);
        $display("including a fill to %0d vertices and back", MAX_V);
        if (sb.errors == 0)
            $display("adjacency_matrix_graph_store_core: match");
        else
            $display("adjacency_matrix_graph_store_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
